>>> sv/sttu_pkg.sv
// Shared types and codes for the session token table.
`timescale 1ns / 1ps
`default_nettype none

package sttu_pkg;

  // Request codes carried in the action field
  typedef enum logic [1:0] {
    ACT_CREATE     = 2'd0,
    ACT_CHECK      = 2'd1,
    ACT_INVALIDATE = 2'd2
  } action_e;

  // Register map (byte address bit 2 selects the register)
  typedef enum logic {
    REG_IDLE_TIMEOUT = 1'b0,
    REG_MAX_AGE      = 1'b1
  } reg_e;

  localparam logic [31:0] IdleTimeoutReset = 32'd1800;
  localparam logic [31:0] MaxAgeReset      = 32'd86400;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB,
    ST_DONE
  } state_e;

  // Write-back kinds
  typedef enum logic [1:0] {
    WB_NONE,
    WB_WRITE,
    WB_CLEAR
  } wb_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] token_high;
    logic [63:0] token_low;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] slot;
  } out_item_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [63:0] token_high;
    logic [63:0] token_low;
    logic [32:0] expiry;
    logic [31:0] issue;
  } slot_entry_t;

  // Flags from the slot compare unit
  typedef struct packed {
    logic expired;
    logic match;
    logic too_old;
    logic earlier;
  } slot_eval_t;

endpackage

`default_nettype wire

>>> sv/sttu_store.sv
// Slot memory with per-slot holds bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sttu_store #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     rd_en_i,
  input  wire  [IW-1:0]           rd_addr_i,
  output sttu_pkg::slot_entry_t   rd_entry_o,
  output logic                    rd_holds_o,
  input  wire                     wr_en_i,
  input  wire                     clr_en_i,
  input  wire  [IW-1:0]           wr_addr_i,
  input  sttu_pkg::slot_entry_t   wr_entry_i
);
  import sttu_pkg::*;

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rd_data_q;
  logic [SLOTS-1:0] holds_q;
  logic rd_holds_q;

  // Memory array: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Holds bits: cleared at reset, a slot without it reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holds_q    <= '0;
      rd_holds_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        holds_q[wr_addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        holds_q[wr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_holds_q <= holds_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_holds_q ? rd_data_q : '0;
  assign rd_holds_o = rd_holds_q;

endmodule

`default_nettype wire

>>> sv/sttu_eval.sv
// Shared compare unit: judges one slot entry against the pending request.
`timescale 1ns / 1ps
`default_nettype none

module sttu_eval (
  input  sttu_pkg::slot_entry_t entry_i,
  input  wire                   holds_i,
  input  wire  [63:0]           token_high_i,
  input  wire  [63:0]           token_low_i,
  input  wire  [31:0]           now_i,
  input  wire  [31:0]           max_age_i,
  input  wire  [32:0]           oldest_i,
  output sttu_pkg::slot_eval_t  res_o
);
  import sttu_pkg::*;

  logic [31:0] age;

  // Age only counts when the clock is not behind the issue time
  assign age = now_i - entry_i.issue;

  always_comb begin
    res_o.expired = entry_i.expiry <= {1'b0, now_i};
    res_o.match   = holds_i && (entry_i.token_high == token_high_i)
                            && (entry_i.token_low == token_low_i);
    res_o.too_old = (now_i >= entry_i.issue) && (age > max_age_i);
    res_o.earlier = entry_i.expiry < oldest_i;
  end

endmodule

`default_nettype wire

>>> sv/session_token_table_unit.sv
// Session token table: top level with register port and scan sequencer.
// Operation: a create, check or invalidate reads one slot per cycle and stops at
// the deciding slot, then passes through the write-back and done states; an unused
// action skips the scan. The result is registered and held while the output stalls.
// One item at a time: the input stalls until the item is through, the scan set by the
// single slot memory read port feeding the shared compare unit.
// Reset clears all holds bits at once (no clearing pass) and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module session_token_table_unit #(
  parameter int SLOTS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sttu_pkg::in_item_t   in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sttu_pkg::out_item_t  out_data_o,
  // register port
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sttu_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] CntEnd  = CW'(SLOTS);
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  state_e      state_q, state_d;
  action_e     action_q, action_d;
  in_item_t    req_q, req_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic        ev_v_q, ev_v_d;
  logic [IW-1:0] ev_idx_q, ev_idx_d;
  logic [IW-1:0] pick_q, pick_d;
  logic [32:0] oldest_q, oldest_d;
  logic        res_ok_q, res_ok_d;
  logic [IW-1:0] res_idx_q, res_idx_d;
  wb_e         wb_kind_q, wb_kind_d;
  logic [31:0] wb_issue_q, wb_issue_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;
  logic [31:0] idle_timeout_q, max_age_q;

  logic        rd_en, wr_en, clr_en, done;
  logic [IW-1:0] rd_addr, pick_new;
  slot_entry_t rd_entry, wr_entry;
  logic        rd_holds;
  slot_eval_t  ev;
  logic [32:0] new_expiry;
  logic        cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= IdleTimeoutReset;
      max_age_q      <= MaxAgeReset;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_IDLE_TIMEOUT: idle_timeout_q <= pwdata;
        REG_MAX_AGE:      max_age_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_IDLE_TIMEOUT: prdata = idle_timeout_q;
      REG_MAX_AGE:      prdata = max_age_q;
      default:          prdata = '0;
    endcase
  end

  // Slot storage and the shared compare unit
  sttu_store #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_entry_o(rd_entry),
    .rd_holds_o(rd_holds),
    .wr_en_i   (wr_en),
    .clr_en_i  (clr_en),
    .wr_addr_i (res_idx_q),
    .wr_entry_i(wr_entry)
  );

  sttu_eval u_eval (
    .entry_i     (rd_entry),
    .holds_i     (rd_holds),
    .token_high_i(req_q.token_high),
    .token_low_i (req_q.token_low),
    .now_i       (req_q.now),
    .max_age_i   (max_age_q),
    .oldest_i    (oldest_q),
    .res_o       (ev)
  );

  assign new_expiry = {1'b0, req_q.now} + {1'b0, idle_timeout_q};

  always_comb begin
    wr_entry.token_high = req_q.token_high;
    wr_entry.token_low  = req_q.token_low;
    wr_entry.expiry     = new_expiry;
    wr_entry.issue      = wb_issue_q;
  end

  // Sequencer: next state and controls
  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    req_d       = req_q;
    rd_cnt_d    = rd_cnt_q;
    ev_v_d      = ev_v_q;
    ev_idx_d    = ev_idx_q;
    pick_d      = pick_q;
    oldest_d    = oldest_q;
    res_ok_d    = res_ok_q;
    res_idx_d   = res_idx_q;
    wb_kind_d   = wb_kind_q;
    wb_issue_d  = wb_issue_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = rd_cnt_q[IW-1:0];
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    done        = 1'b0;
    pick_new    = pick_q;

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          action_d  = action_e'(in_data_i.action);
          rd_cnt_d  = '0;
          ev_v_d    = 1'b0;
          res_ok_d  = 1'b0;
          res_idx_d = '0;
          wb_kind_d = WB_NONE;
          case (action_e'(in_data_i.action))
            ACT_CREATE, ACT_CHECK, ACT_INVALIDATE: state_d = ST_SCAN;
            default:                               state_d = ST_WB;
          endcase
        end
      end

      ST_SCAN: begin
        // judge the slot read in the previous cycle
        if (ev_v_q) begin
          case (action_q)
            ACT_CREATE: begin
              if (ev.expired) begin
                done       = 1'b1;
                res_ok_d   = 1'b1;
                res_idx_d  = ev_idx_q;
                wb_kind_d  = WB_WRITE;
                wb_issue_d = req_q.now;
              end else begin
                if (ev_idx_q == '0 || ev.earlier) begin
                  pick_new = ev_idx_q;
                  oldest_d = rd_entry.expiry;
                end
                pick_d = pick_new;
                if (ev_idx_q == LastIdx) begin
                  done       = 1'b1;
                  res_ok_d   = 1'b1;
                  res_idx_d  = pick_new;
                  wb_kind_d  = WB_WRITE;
                  wb_issue_d = req_q.now;
                end
              end
            end
            ACT_CHECK: begin
              if (!ev.expired && ev.match) begin
                done = 1'b1;
                if (!ev.too_old) begin
                  res_ok_d   = 1'b1;
                  res_idx_d  = ev_idx_q;
                  wb_kind_d  = WB_WRITE;
                  wb_issue_d = rd_entry.issue;
                end
              end else if (ev_idx_q == LastIdx) begin
                done = 1'b1;
              end
            end
            ACT_INVALIDATE: begin
              if (ev.match) begin
                done      = 1'b1;
                res_ok_d  = 1'b1;
                res_idx_d = ev_idx_q;
                wb_kind_d = WB_CLEAR;
              end else if (ev_idx_q == LastIdx) begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end

        // issue the next slot read
        if (done) begin
          ev_v_d  = 1'b0;
          state_d = ST_WB;
        end else if (rd_cnt_q < CntEnd) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
          ev_v_d   = 1'b1;
          ev_idx_d = rd_cnt_q[IW-1:0];
        end else begin
          ev_v_d = 1'b0;
        end
      end

      ST_WB: begin
        case (wb_kind_q)
          WB_WRITE: wr_en  = 1'b1;
          WB_CLEAR: clr_en = 1'b1;
          default: ;
        endcase
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_data_d.ok   = res_ok_q;
          out_data_d.slot = 4'(res_idx_q);
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      ev_v_q      <= 1'b0;
      wb_kind_q   <= WB_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      ev_v_q      <= ev_v_d;
      wb_kind_q   <= wb_kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    req_q      <= req_d;
    ev_idx_q   <= ev_idx_d;
    pick_q     <= pick_d;
    oldest_q   <= oldest_d;
    res_ok_q   <= res_ok_d;
    res_idx_q  <= res_idx_d;
    wb_issue_q <= wb_issue_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the sequencer
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted transfer did not start work");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.slot == '0)
    else $error("failed result carries a nonzero slot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CntEnd)
    else $error("scan counter ran past the table");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_v_q |-> state_q == ST_SCAN)
    else $error("slot compare pending outside scan");

  a_wb_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB && wb_kind_q != WB_NONE |-> $past(state_q) == ST_SCAN)
    else $error("write-back without a scan");

endmodule

`default_nettype wire

>>> tb/session_token_table_unit_tb.sv
// Testbench for the session token table: directed script, then random traffic checked by a predictor.
`timescale 1ns / 1ps

module session_token_table_unit_tb;
  import sttu_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_SIZE = 20;
  // action code with no operation behind it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [127:0] TOKEN_ZERO = '0;
  localparam logic [127:0] TOKEN_ONES = '1;
  localparam logic [127:0] TOKEN_A = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
  localparam logic [127:0] TOKEN_B = 128'h8000_0000_0000_0001_8000_0000_0000_0001;
  localparam logic [127:0] TOKEN_C = 128'h5a5a_a5a5_c3c3_3c3c_0f0f_f0f0_1234_4321;

  // One line of the directed script: a register write or a request
  typedef struct packed {
    bit          is_cfg;
    reg_e        cfg_reg;
    logic [31:0] cfg_val;
    logic [1:0]  act;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] now;
    bit          typed;
    logic        ok;
    logic [3:0]  slot;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  session_token_table_unit u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Predicted table contents and registers
  logic [63:0] tbl_hi [SLOTS];
  logic [63:0] tbl_lo [SLOTS];
  logic [32:0] tbl_expiry [SLOTS];
  logic [31:0] tbl_issue [SLOTS];
  bit          tbl_held [SLOTS];
  logic [31:0] cur_idle;
  logic [31:0] cur_max_age;

  out_item_t   pending_answers [$];
  step_t       script [$];
  logic [127:0] token_pool [POOL_SIZE];
  logic [31:0] wall_time;
  logic [31:0] phase_idle [RANDOM_PHASES];
  logic [31:0] phase_age [RANDOM_PHASES];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  requests_sent = 0;
  bit  in_steady = 1'b0;
  int  answers_seen = 0;
  int  answers_paced = 0;
  int  out_pause = 0;
  bit  out_steady = 1'b0;
  bit  out_hold = 1'b0;
  bit  random_running = 1'b0;
  out_item_t answer_due;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) begin
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Table update for one request; returns the answer the block owes
  function automatic out_item_t apply_session_request(input in_item_t rq);
    out_item_t   res;
    int          pick;
    logic [32:0] oldest;
    logic [32:0] now_w;
    logic [32:0] renew;
    logic [31:0] age;
    bit          done;
    res = '0;
    now_w = {1'b0, rq.now};
    renew = now_w + {1'b0, cur_idle};
    done = 1'b0;
    case (rq.action)
      ACT_CREATE: begin
        // first expired slot, else earliest expiry (lowest index on ties)
        pick = 0;
        oldest = tbl_expiry[0];
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (tbl_expiry[i] <= now_w) begin
            pick = i;
            done = 1'b1;
          end else if (tbl_expiry[i] < oldest) begin
            oldest = tbl_expiry[i];
            pick = i;
          end
        end
        {tbl_hi[pick], tbl_lo[pick]} = {rq.token_high, rq.token_low};
        tbl_expiry[pick] = renew;
        tbl_issue[pick] = rq.now;
        tbl_held[pick] = 1'b1;
        res.ok = 1'b1;
        res.slot = pick[3:0];
      end
      ACT_CHECK: begin
        // first live match decides; too old stops the scan
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (tbl_expiry[i] > now_w && tbl_held[i] && tbl_hi[i] == rq.token_high &&
              tbl_lo[i] == rq.token_low) begin
            done = 1'b1;
            age = (rq.now >= tbl_issue[i]) ? rq.now - tbl_issue[i] : '0;
            if (age <= cur_max_age) begin
              tbl_expiry[i] = renew;
              res.ok = 1'b1;
              res.slot = i[3:0];
            end
          end
        end
      end
      ACT_INVALIDATE: begin
        // clears a match whether expired or not
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (tbl_held[i] && tbl_hi[i] == rq.token_high && tbl_lo[i] == rq.token_low) begin
            done = 1'b1;
            tbl_hi[i] = '0;
            tbl_lo[i] = '0;
            tbl_expiry[i] = '0;
            tbl_issue[i] = '0;
            tbl_held[i] = 1'b0;
            res.ok = 1'b1;
            res.slot = i[3:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic step_t op(input logic [1:0] act, input logic [127:0] tok,
                               input logic [31:0] now, input bit typed = 1'b0,
                               input logic ok = 1'b0, input logic [3:0] slot = '0);
    step_t s;
    s = '0;
    s.act = act;
    {s.hi, s.lo} = tok;
    s.now = now;
    s.typed = typed;
    s.ok = ok;
    s.slot = slot;
    return s;
  endfunction

  function automatic step_t cfg_step(input reg_e r, input logic [31:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_reg = r;
    s.cfg_val = v;
    return s;
  endfunction

  // Random request: mostly pooled tokens on a slowly advancing clock
  function automatic step_t random_step();
    logic [1:0]   act;
    logic [127:0] tok;
    logic [31:0]  now;
    int           r;
    r = $urandom_range(0, 99);
    if (r < 36) act = ACT_CREATE;
    else if (r < 76) act = ACT_CHECK;
    else if (r < 95) act = ACT_INVALIDATE;
    else act = ACT_UNUSED;
    if ($urandom_range(0, 99) < 88) tok = token_pool[$urandom_range(0, POOL_SIZE - 1)];
    else tok = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 3) begin
      now = $urandom;
    end else if (r < 7) begin
      now = wall_time - $urandom_range(0, 40);
    end else if (r < 9) begin
      now = 32'hFFFF_FFFF - $urandom_range(0, 2);
    end else begin
      wall_time += $urandom_range(0, 12);
      now = wall_time;
    end
    return op(act, tok, now);
  endfunction

  task automatic read_reg(input reg_e r);
    logic [31:0] want;
    want = (r == REG_IDLE_TIMEOUT) ? cur_idle : cur_max_age;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("reg %s read %0h want %0h", r.name(), prdata, want));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_IDLE_TIMEOUT) cur_idle = v;
    else cur_max_age = v;
    read_reg(r);
  endtask

  // Offer one request after a random gap; valid stays up across back-to-back transfers
  task automatic send_request(input step_t s);
    in_item_t  rq;
    out_item_t want;
    int        gap;
    rq.action = s.act;
    rq.token_high = s.hi;
    rq.token_low = s.lo;
    rq.now = s.now;
    if (requests_sent % 32 == 0) in_steady = ($urandom_range(0, 3) == 0);
    gap = in_steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    want = apply_session_request(rq);
    if (s.typed) begin
      want.ok = s.ok;
      want.slot = s.slot;
    end
    pending_answers.push_back(want);
    requests_sent++;
  endtask

  // Let every owed answer arrive, then watch for stray ones
  task automatic drain_answers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("result transfer with no request pending");
      end else begin
        answer_due = pending_answers.pop_front();
        if (out_data_o.ok !== answer_due.ok) begin
          report_mismatch($sformatf("ok got %b want %b", out_data_o.ok, answer_due.ok));
        end
        if (out_data_o.slot !== answer_due.slot) begin
          report_mismatch($sformatf("slot got %0d want %0d", out_data_o.slot,
                                    answer_due.slot));
        end
      end
    end
  end

  // Receiver pacing: a random pause after each result, plus the long hold-off
  always @(negedge clk_i) begin
    if (answers_seen != answers_paced) begin
      answers_paced = answers_seen;
      if (answers_seen % 32 == 0) out_steady = ($urandom_range(0, 3) == 0);
      out_pause = out_steady ? 0 : $urandom_range(0, 4);
    end
    out_stall_i <= out_hold || (out_pause > 0);
    if (out_pause > 0) out_pause--;
  end

  // Long output stall while requests keep coming, so the input backs up
  initial begin
    wait (random_running);
    repeat (300) @(posedge clk_i);
    out_hold = 1'b1;
    repeat (500) @(posedge clk_i);
    out_hold = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    step_t s;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_hi[i] = '0;
      tbl_lo[i] = '0;
      tbl_expiry[i] = '0;
      tbl_issue[i] = '0;
      tbl_held[i] = 1'b0;
    end
    cur_idle = IdleTimeoutReset;
    cur_max_age = MaxAgeReset;
    token_pool[0] = TOKEN_ZERO;
    token_pool[1] = TOKEN_ONES;
    for (int i = 2; i < POOL_SIZE; i++) begin
      token_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    end
    phase_idle = '{1800, 40, 0, 32'hFFFF_FFFF, 300, $urandom_range(1, 500)};
    phase_age = '{86400, 25, 0, 32'hFFFF_FFFF, 60, $urandom};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    read_reg(REG_IDLE_TIMEOUT);
    read_reg(REG_MAX_AGE);

    // Directed script; answers typed in where they follow directly from the rules
    script.push_back(op(ACT_INVALIDATE, TOKEN_ZERO, 0, 1, 0, 0));  // zero token, empty table
    script.push_back(op(ACT_CHECK, TOKEN_ZERO, 0, 1, 0, 0));
    script.push_back(op(ACT_UNUSED, TOKEN_ONES, 32'hFFFF_FFFF, 1, 0, 0));
    script.push_back(op(ACT_CREATE, TOKEN_ONES, 0, 1, 1, 0));
    script.push_back(op(ACT_CREATE, TOKEN_A, 0, 1, 1, 1));
    script.push_back(op(ACT_CHECK, TOKEN_ONES, 100, 1, 1, 0));
    script.push_back(op(ACT_CHECK, TOKEN_ZERO, 100, 1, 0, 0));
    script.push_back(op(ACT_INVALIDATE, TOKEN_A, 200, 1, 1, 1));
    script.push_back(op(ACT_CHECK, TOKEN_A, 200, 1, 0, 0));
    script.push_back(op(ACT_INVALIDATE, TOKEN_ZERO, 200, 1, 0, 0)); // cleared slot must not match
    script.push_back(op(ACT_CREATE, TOKEN_B, 32'hFFFF_FFFF));       // expiry needs the 33rd bit
    script.push_back(op(ACT_CHECK, TOKEN_B, 32'hFFFF_FFFF));
    script.push_back(op(ACT_CHECK, TOKEN_B, 0));                     // clock behind issue
    script.push_back(cfg_step(REG_IDLE_TIMEOUT, 32'hFFFF_FFFF));
    script.push_back(cfg_step(REG_MAX_AGE, 0));
    script.push_back(op(ACT_CREATE, TOKEN_C, 5));
    script.push_back(op(ACT_CREATE, TOKEN_C, 7));
    script.push_back(op(ACT_CHECK, TOKEN_C, 6));                     // too old, scan stops
    script.push_back(op(ACT_CHECK, TOKEN_C, 5));
    script.push_back(cfg_step(REG_MAX_AGE, 32'hFFFF_FFFF));
    script.push_back(op(ACT_CHECK, TOKEN_C, 32'hFFFF_FFFE));
    script.push_back(cfg_step(REG_IDLE_TIMEOUT, 0));
    script.push_back(op(ACT_CREATE, TOKEN_A, 50));                   // born expired
    script.push_back(op(ACT_CHECK, TOKEN_A, 50));
    script.push_back(op(ACT_INVALIDATE, TOKEN_A, 60));               // expired, still cleared

    foreach (script[i]) begin
      s = script[i];
      if (s.is_cfg) begin
        drain_answers();
        write_reg(s.cfg_reg, s.cfg_val);
      end else begin
        send_request(s);
      end
    end

    // Random phases, one register setting each
    random_running = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_answers();
      write_reg(REG_IDLE_TIMEOUT, phase_idle[p]);
      write_reg(REG_MAX_AGE, phase_age[p]);
      wall_time = (p % 2 == 0) ? $urandom_range(0, 5000) : $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_step());
      end
    end
    drain_answers();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sttu_pkg.sv
sv/sttu_store.sv
sv/sttu_eval.sv
sv/session_token_table_unit.sv
tb/session_token_table_unit_tb.sv
